/* hw/rtl/yuvtp_pkg.sv */
package yuvtp_pkg;

   localparam int DIM_W     = 13;
   localparam int IDX_W     = 12;
   localparam int PLANE_W   = 2;
   localparam int LEVEL_W   = 8;
   localparam int STEP_W    = 24;
   localparam int ADDR_W    = 25;
   localparam int LSIZE_W   = 2 * DIM_W;
   localparam int MULT_W    = DIM_W;
   localparam int RAMP_W    = MULT_W + STEP_W;
   localparam int FRAC_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA_LEVEL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP    = 2'd3;

   localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd256;
   localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd256;
   localparam logic [LEVEL_W-1:0] RST_LUMA_LEVEL   = 8'd128;
   localparam logic [STEP_W-1:0]  RST_RAMP_STEP    = 24'd65536;

   localparam logic [PLANE_W-1:0] PLANE_Y      = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_U      = 2'd1;
   localparam logic [PLANE_W-1:0] PLANE_V      = 2'd2;
   localparam logic [PLANE_W-1:0] PLANE_UNUSED = 2'd3;

   localparam logic [LEVEL_W-1:0] CHROMA_BG = 8'd128;
   localparam logic [LEVEL_W-1:0] LUMA_BG   = 8'd0;
   localparam logic [LEVEL_W-1:0] SAMPLE_MAX = 8'd255;
   localparam logic [RAMP_W:0]    ROUND_HALF = (RAMP_W+1)'(1) << (FRAC_W - 1);

   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [DIM_W-1:0]   side;
      logic [LEVEL_W-1:0] luma_level;
      logic [STEP_W-1:0]  ramp_step;
   } cfg_type;

   typedef struct packed {
      logic [PLANE_W-1:0] plane;
      logic               in_luma_sq;
      logic               in_chroma_sq;
      logic [IDX_W-1:0]   col;
      logic [ADDR_W-1:0]  row_offset;
      logic [LSIZE_W-1:0] luma_size;
      logic [RAMP_W-1:0]  ramp;
   } prod_type;

endpackage

/* hw/rtl/yuvtp_cfg.sv */
module yuvtp_cfg
   import yuvtp_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STEP_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   logic [DIM_W-1:0]   width_ff,  width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [LEVEL_W-1:0] level_ff,  level_in;
   logic [STEP_W-1:0]  step_ff,   step_in;
   logic [DIM_W-1:0]   w_eff, h_eff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      level_in  = level_ff;
      step_in   = step_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT: height_in = csr_wdata[DIM_W-1:0];
            CSR_LUMA_LEVEL:   level_in  = csr_wdata[LEVEL_W-1:0];
            CSR_RAMP_STEP:    step_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_FRAME_WIDTH;
         height_ff <= RST_FRAME_HEIGHT;
         level_ff  <= RST_LUMA_LEVEL;
         step_ff   <= RST_RAMP_STEP;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         level_ff  <= level_in;
         step_ff   <= step_in;
      end
   end

   // dimensions above MAX_DIM are used as MAX_DIM
   assign w_eff = (32'(width_ff)  > MAX_DIM) ? DIM_W'(MAX_DIM) : width_ff;
   assign h_eff = (32'(height_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_ff;

   assign cfg.width      = w_eff;
   assign cfg.height     = h_eff;
   assign cfg.side       = (w_eff < h_eff) ? w_eff : h_eff;
   assign cfg.luma_level = level_ff;
   assign cfg.ramp_step  = step_ff;

endmodule

/* hw/rtl/yuvtp_mul.sv */
module yuvtp_mul
   import yuvtp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [PLANE_W-1:0] in_plane,
   input  logic [IDX_W-1:0]   in_row,
   input  logic [IDX_W-1:0]   in_col,
   output logic               prod_valid,
   input  logic               prod_ready,
   output prod_type           prod
);

   logic               s1_valid_ff, s1_valid_in;
   logic [PLANE_W-1:0] plane_ff;
   logic [IDX_W-1:0]   row_ff, col_ff;
   logic               s2_valid_ff, s2_valid_in;
   prod_type           prod_ff, prod_in;
   logic               s2_ready, s1_load, s2_load;
   logic [DIM_W-1:0]   half_side, row_mult, ramp_mult, row_x2, col_x2;

   assign s2_ready = !s2_valid_ff || prod_ready;
   assign in_ready = !s1_valid_ff || s2_ready;
   assign s1_load  = in_valid && in_ready;
   assign s2_load  = s1_valid_ff && s2_ready;

   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_ready);
   assign s2_valid_in = s2_load || (s2_valid_ff && !prod_ready);

   assign half_side = cfg.side >> 1;
   assign row_x2    = {row_ff, 1'b0};
   assign col_x2    = {col_ff, 1'b0};
   assign row_mult  = (plane_ff == PLANE_Y) ? cfg.width : (cfg.width >> 1);
   assign ramp_mult = (plane_ff == PLANE_V) ? (cfg.side - row_x2) : col_x2;

   always_comb begin
      prod_in.plane        = plane_ff;
      prod_in.in_luma_sq   = (DIM_W'(row_ff) < cfg.side) && (DIM_W'(col_ff) < cfg.side);
      prod_in.in_chroma_sq = (DIM_W'(row_ff) < half_side) && (DIM_W'(col_ff) < half_side);
      prod_in.col          = col_ff;
      prod_in.row_offset   = ADDR_W'(row_ff * row_mult);
      prod_in.luma_size    = cfg.width * cfg.height;
      prod_in.ramp         = ramp_mult * cfg.ramp_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         plane_ff <= in_plane;
         row_ff   <= in_row;
         col_ff   <= in_col;
      end
      if (s2_load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = s2_valid_ff;
   assign prod       = prod_ff;

endmodule

/* hw/rtl/yuvtp_fin.sv */
module yuvtp_fin
   import yuvtp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [LEVEL_W-1:0] luma_level,
   input  logic               prod_valid,
   output logic               prod_ready,
   input  prod_type           prod,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [LEVEL_W-1:0] out_value,
   output logic [ADDR_W-1:0]  out_addr
);

   logic                  valid_ff, valid_in;
   logic [LEVEL_W-1:0]    value_ff, value_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  load;
   logic [RAMP_W:0]       rounded;
   logic [RAMP_W-FRAC_W:0] ramp_int;
   logic [LEVEL_W-1:0]    ramp_sat;
   logic [LSIZE_W-1:0]    v_base;
   logic [ADDR_W-1:0]     base;

   assign prod_ready = !valid_ff || out_ready;
   assign load       = prod_valid && prod_ready;
   assign valid_in   = load || (valid_ff && !out_ready);

   assign rounded  = (RAMP_W+1)'(prod.ramp) + ROUND_HALF;
   assign ramp_int = rounded[RAMP_W:FRAC_W];
   assign ramp_sat = (|ramp_int[RAMP_W-FRAC_W:LEVEL_W]) ? SAMPLE_MAX
                                                        : ramp_int[LEVEL_W-1:0];
   assign v_base   = prod.luma_size + (prod.luma_size >> 2);

   always_comb begin
      unique case (prod.plane)
         PLANE_Y: begin
            base     = '0;
            value_in = prod.in_luma_sq ? luma_level : LUMA_BG;
         end
         PLANE_U: begin
            base     = prod.luma_size[ADDR_W-1:0];
            value_in = prod.in_chroma_sq ? ramp_sat : CHROMA_BG;
         end
         PLANE_V: begin
            base     = v_base[ADDR_W-1:0];
            value_in = prod.in_chroma_sq ? ramp_sat : CHROMA_BG;
         end
         default: begin
            base     = '0;
            value_in = '0;
         end
      endcase
      if (prod.plane == PLANE_UNUSED) begin
         addr_in = '0;
      end else begin
         addr_in = base + prod.row_offset + ADDR_W'(prod.col);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         addr_ff  <= addr_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_addr  = addr_ff;

endmodule

/* hw/rtl/yuv420_gradient_test_pattern.sv */
// YUV 4:2:0 gradient test pattern source, one sample per request.
// req: one transfer names a plane (tuser) and a row and column in it (tdata).
// rsp: one transfer per request, the sample byte and its offset in the
//      planar buffer (Y plane, then U, then V), in request order.
// csr: write-only registers, taken on any cycle with csr_wr_en high:
//      0 frame width, 1 frame height, 2 luma level, 3 ramp step (8.16).
// Throughput: one request per cycle, sustained while rsp_tready is high.
// Three register stages (request, products, result) lie between a request
// transfer and its result on rsp.
// The multipliers of the product stage set the clock period.
// Reset empties all stages and loads 256x256, luma 128, step 1.0.
// A stalled rsp holds its result; the earlier stages keep accepting
// requests until they are full, then req_tready drops.
module yuv420_gradient_test_pattern
   import yuvtp_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // row_index, col_index
   input  logic [PLANE_W-1:0]   req_tuser,   // plane_sel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // sample_value, byte_address, zero fill
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STEP_W-1:0]    csr_wdata
);

   cfg_type            cfg;
   prod_type           prod;
   logic               prod_valid, prod_ready;
   logic [LEVEL_W-1:0] value;
   logic [ADDR_W-1:0]  addr;

   yuvtp_cfg #(
      .MAX_DIM (MAX_DIM)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   yuvtp_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_plane   (req_tuser),
      .in_row     (req_tdata[IDX_W-1:0]),
      .in_col     (req_tdata[2*IDX_W-1:IDX_W]),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   yuvtp_fin u_fin (
      .clock      (clock),
      .reset      (reset),
      .luma_level (cfg.luma_level),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (value),
      .out_addr   (addr)
   );

   assign rsp_tdata = {7'd0, addr, value};

endmodule
